// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the checker files.
// Each macro expects clk in scope; the first two also expect rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is applied
`define CHK_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// Next-cycle implication, ignored while reset is applied
`define CHK_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

// Next-cycle implication that is also checked during reset
`define CHK_RST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("check failed: reset behavior");

`endif

// ----- rtl/woc_pkg.sv -----
`default_nettype none
package woc_pkg;

  // Field widths
  localparam int COORD_BITS = 16;
  localparam int AREA_BITS  = 32;
  localparam int PROD_BITS  = 2 * COORD_BITS;

  // Input word modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] dim_t;
  typedef logic        [AREA_BITS-1:0]  area_t;

  // One input word
  typedef struct packed {
    logic   mode;
    coord_t win_x1;
    coord_t win_y1;
    coord_t win_x2;
    coord_t win_y2;
    dim_t   win_width;
    dim_t   win_height;
  } win_word_t;

  // One result word
  typedef struct packed {
    logic   paint_needed;
    coord_t region_x1;
    coord_t region_y1;
    coord_t region_x2;
    coord_t region_y2;
  } res_word_t;

  // Rectangle edges
  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } rect_t;

  // Area is the product kept modulo 2^AREA_BITS
  function automatic area_t area_of(dim_t w, dim_t h);
    logic [PROD_BITS-1:0] prod;
    prod = PROD_BITS'(w) * PROD_BITS'(h);
    return AREA_BITS'(prod);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/woc_in_stage.sv -----
`default_nettype none
module woc_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire woc_pkg::win_word_t in_word,
  input  wire logic              advance,
  output logic                   s1_valid,
  output woc_pkg::win_word_t     s1_word,
  output woc_pkg::area_t         s1_area
);

  logic               s1_valid_r, s1_valid_nxt;
  woc_pkg::win_word_t s1_word_r;
  woc_pkg::area_t     s1_area_r;
  logic               take;

  // Hold the word while the update stage cannot move it on
  assign in_stall = s1_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!s1_valid_r || advance) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture the word and its window area
  always_ff @(posedge clk) begin
    if (take) begin
      s1_word_r <= in_word;
      s1_area_r <= woc_pkg::area_of(in_word.win_width, in_word.win_height);
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_word_r;
  assign s1_area  = s1_area_r;

endmodule
`default_nettype wire

// ----- rtl/woc_region.sv -----
`default_nettype none
module woc_region (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               upd,
  input  wire woc_pkg::win_word_t win,
  input  wire woc_pkg::area_t     win_area,
  output woc_pkg::res_word_t      res
);

  woc_pkg::rect_t ig_r, ig_nxt;
  woc_pkg::area_t ig_area_r, ig_area_nxt;
  woc_pkg::rect_t win_rect;
  woc_pkg::rect_t ov;
  woc_pkg::dim_t  ov_w;
  woc_pkg::dim_t  ov_h;
  woc_pkg::area_t ov_area;
  logic           encl;
  logic           meets;
  logic           paint;

  // Region update for one window
  always_comb begin
    win_rect = '{x1: win.win_x1, y1: win.win_y1, x2: win.win_x2, y2: win.win_y2};

    encl = ($signed(ig_r.x1) <= $signed(win_rect.x1)) &&
           ($signed(ig_r.y1) <= $signed(win_rect.y1)) &&
           ($signed(ig_r.x2) >= $signed(win_rect.x2)) &&
           ($signed(ig_r.y2) >= $signed(win_rect.y2));

    // touching edges count as overlap
    meets = !(($signed(ig_r.x1) > $signed(win_rect.x2)) ||
              ($signed(win_rect.x1) > $signed(ig_r.x2)) ||
              ($signed(ig_r.y1) > $signed(win_rect.y2)) ||
              ($signed(win_rect.y1) > $signed(ig_r.y2)));

    ov.x1 = ($signed(ig_r.x1) > $signed(win_rect.x1)) ? ig_r.x1 : win_rect.x1;
    ov.y1 = ($signed(ig_r.y1) > $signed(win_rect.y1)) ? ig_r.y1 : win_rect.y1;
    ov.x2 = ($signed(ig_r.x2) < $signed(win_rect.x2)) ? ig_r.x2 : win_rect.x2;
    ov.y2 = ($signed(ig_r.y2) < $signed(win_rect.y2)) ? ig_r.y2 : win_rect.y2;

    // size wraps for malformed rectangles
    ov_w    = woc_pkg::dim_t'(ov.x2 - ov.x1);
    ov_h    = woc_pkg::dim_t'(ov.y2 - ov.y1);
    ov_area = woc_pkg::area_of(ov_w, ov_h);

    ig_nxt      = ig_r;
    ig_area_nxt = ig_area_r;
    paint       = 1'b0;
    if (win.mode == woc_pkg::MODE_LOAD) begin
      ig_nxt      = win_rect;
      ig_area_nxt = win_area;
    end else if (!encl) begin
      paint = 1'b1;
      if (win_area > ig_area_r) begin
        ig_nxt      = win_rect;
        ig_area_nxt = win_area;
      end
      if (meets && (ov_area > ig_area_nxt)) begin
        ig_nxt      = ov;
        ig_area_nxt = ov_area;
      end
    end

    res = '{paint_needed: paint, region_x1: ig_nxt.x1, region_y1: ig_nxt.y1,
            region_x2: ig_nxt.x2, region_y2: ig_nxt.y2};
  end

  // Ignore region and its area
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ig_r      <= '0;
      ig_area_r <= '0;
    end else if (upd) begin
      ig_r      <= ig_nxt;
      ig_area_r <= ig_area_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/window_occlusion_culler.sv -----
`default_nettype none
// Occlusion culler for window rectangles. Each input word either loads the
// ignore region (mode 0) or tests a window against it (mode 1); every word
// yields exactly one result word with the paint flag and the region as it
// stands after that word. One word is taken per clock cycle when the output
// side does not stall. Its result word passes through the input register
// and the result register, which holds it while the output side stalls.
// The window area is multiplied in the input register stage; the region
// update (containment and overlap compares, overlap multiply, area compare)
// is combinational between the two registers because each window works
// on the region the previous one left behind.
module window_occlusion_culler (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire woc_pkg::win_word_t in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output woc_pkg::res_word_t      out_word
);

  logic               advance;
  logic               upd;
  logic               s1_valid;
  woc_pkg::win_word_t s1_word;
  woc_pkg::area_t     s1_area;
  woc_pkg::res_word_t res;
  logic               out_valid_r, out_valid_nxt;
  woc_pkg::res_word_t out_word_r;

  // Output register frees up when empty or being taken
  assign advance = !out_valid_r || !out_stall;
  assign upd     = s1_valid && advance;

  woc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_word  (s1_word),
    .s1_area  (s1_area)
  );

  woc_region u_region (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .win      (s1_word),
    .win_area (s1_area),
    .res      (res)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// ----- rtl/woc_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module woc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire woc_pkg::res_word_t out_word
);

  // A stalled result word holds
  `CHK_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // Reset empties the result register
  `CHK_RST_NXT(a_rst_empty, !rst_n, !out_valid)

  // A free output side never back-pressures the input
  `CHK_IMP(a_no_false_stall, !out_valid || !out_stall, !in_stall)

  // An accepted word reaches the output once the output register can take it
  `CHK_NXT(a_latency, (in_valid && !in_stall) ##1 (!out_valid || !out_stall), out_valid)

endmodule

bind window_occlusion_culler woc_checker u_woc_checker (.*);
`default_nettype wire
